/* hw/rtl/raster_copy_region_clamp_macros.svh */
// Assertion macros for the raster copy region clamp block.
`ifndef RASTER_COPY_REGION_CLAMP_MACROS_SVH
`define RASTER_COPY_REGION_CLAMP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define RCRC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define RCRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RCRC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RCRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/rcrc_pkg.sv */
// Shared types and constants of the raster copy region clamp block.
`timescale 1ns / 1ps

package rcrc_pkg;

  localparam int LEVEL_IN_W  = 5;
  localparam int LEVEL_OUT_W = 4;
  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SIZE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LEVEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_SIZE          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_LEVEL_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTISAMPLE_MODES  = 3'd4;

  // Reset values: 1x1x1 images, one level, no multisampling
  localparam logic [SIZE_W-1:0]     SIZE_RESET  = 48'h0001_0001_0001;
  localparam logic [LEVEL_IN_W-1:0] COUNT_RESET = 5'd1;

  // Image indexes inside per-image arrays
  localparam int IMG_SRC = 0;
  localparam int IMG_DST = 1;

  typedef struct packed {
    logic [SIZE_W-1:0]     source_size;
    logic [LEVEL_IN_W-1:0] source_level_count;
    logic [SIZE_W-1:0]     dest_size;
    logic [LEVEL_IN_W-1:0] dest_level_count;
    logic [1:0]            multisample_modes;
  } cfg_t;

  typedef struct packed {
    logic [1:0][LEVEL_IN_W-1:0]   level;
    logic [1:0][2:0][COORD_W-1:0] origin;
    logic [2:0][COORD_W-1:0]      size;
    logic                         last;
  } req_t;

  typedef struct packed {
    logic [1:0][LEVEL_OUT_W-1:0]  level;
    logic [1:0][2:0][COORD_W-1:0] origin;
    logic [2:0][COORD_W-1:0]      size;
    logic                         last;
  } res_t;

endpackage

/* hw/rtl/rcrc_if.sv */
// Channel interfaces: copy request, clamped result and configuration write.
`timescale 1ns / 1ps

interface rcrc_req_if;
  import rcrc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [LEVEL_IN_W-1:0] src_level;
  logic [COORD_W-1:0]    src_x;
  logic [COORD_W-1:0]    src_y;
  logic [COORD_W-1:0]    src_z;
  logic [LEVEL_IN_W-1:0] dst_level;
  logic [COORD_W-1:0]    dst_x;
  logic [COORD_W-1:0]    dst_y;
  logic [COORD_W-1:0]    dst_z;
  logic [COORD_W-1:0]    copy_width;
  logic [COORD_W-1:0]    copy_height;
  logic [COORD_W-1:0]    copy_depth;
  logic                  last_in;

  modport source (output valid, src_level, src_x, src_y, src_z, dst_level, dst_x, dst_y,
                  dst_z, copy_width, copy_height, copy_depth, last_in, input ready);
  modport sink (input valid, src_level, src_x, src_y, src_z, dst_level, dst_x, dst_y,
                dst_z, copy_width, copy_height, copy_depth, last_in, output ready);
endinterface

interface rcrc_res_if;
  import rcrc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [LEVEL_OUT_W-1:0] out_src_level;
  logic [COORD_W-1:0]     out_src_x;
  logic [COORD_W-1:0]     out_src_y;
  logic [COORD_W-1:0]     out_src_z;
  logic [LEVEL_OUT_W-1:0] out_dst_level;
  logic [COORD_W-1:0]     out_dst_x;
  logic [COORD_W-1:0]     out_dst_y;
  logic [COORD_W-1:0]     out_dst_z;
  logic [COORD_W-1:0]     out_width;
  logic [COORD_W-1:0]     out_height;
  logic [COORD_W-1:0]     out_depth;
  logic                   last_out;

  modport source (output valid, out_src_level, out_src_x, out_src_y, out_src_z,
                  out_dst_level, out_dst_x, out_dst_y, out_dst_z, out_width, out_height,
                  out_depth, last_out, input ready);
  modport sink (input valid, out_src_level, out_src_x, out_src_y, out_src_z,
                out_dst_level, out_dst_x, out_dst_y, out_dst_z, out_width, out_height,
                out_depth, last_out, output ready);
endinterface

interface rcrc_cfg_if;
  import rcrc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rcrc_prep.sv */
// Stage 1: clamp both level indices and sanitize the base image sizes.
`timescale 1ns / 1ps

module rcrc_prep #(
  parameter int MAX_LEVELS  = 16,
  parameter int EXTENT_BITS = 16,
  parameter int LVL_W       = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  rcrc_pkg::req_t                        up_req,
  input  rcrc_pkg::cfg_t                        cfg,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [1:0][LVL_W-1:0]                 dn_level,
  output logic [1:0][2:0][EXTENT_BITS-1:0]      dn_base,
  output logic [1:0][2:0][rcrc_pkg::COORD_W-1:0] dn_origin,
  output logic [2:0][rcrc_pkg::COORD_W-1:0]     dn_size,
  output logic                                  dn_last
);
  import rcrc_pkg::*;

  localparam int EXT_MAX = (1 << EXTENT_BITS) - 1;

  logic                              valid_r;
  logic [1:0][LVL_W-1:0]             level_r, level_nxt;
  logic [1:0][2:0][EXTENT_BITS-1:0]  base_r, base_nxt;
  logic [1:0][2:0][COORD_W-1:0]      origin_r;
  logic [2:0][COORD_W-1:0]           size_r;
  logic                              last_r;

  // Clamp a requested level to the sanitized level count minus one
  function automatic logic [LVL_W-1:0] clamp_level(input logic [LEVEL_IN_W-1:0] req,
                                                   input logic [LEVEL_IN_W-1:0] cnt);
    logic [LEVEL_IN_W-1:0] top;
    if (cnt == '0) begin
      top = '0;
    end else if ({1'b0, cnt} > (LEVEL_IN_W + 1)'(MAX_LEVELS)) begin
      top = LEVEL_IN_W'(MAX_LEVELS - 1);
    end else begin
      top = cnt - LEVEL_IN_W'(1);
    end
    return (req < top) ? LVL_W'(req) : LVL_W'(top);
  endfunction

  // Treat zero as one and saturate at the widest extent
  function automatic logic [EXTENT_BITS-1:0] size_field(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] s;
    if (v == '0) begin
      s = COORD_W'(1);
    end else if (v > COORD_W'(EXT_MAX)) begin
      s = COORD_W'(EXT_MAX);
    end else begin
      s = v;
    end
    return EXTENT_BITS'(s);
  endfunction

  // Compute levels and base sizes
  always_comb begin
    level_nxt[IMG_SRC] = clamp_level(up_req.level[IMG_SRC], cfg.source_level_count);
    level_nxt[IMG_DST] = clamp_level(up_req.level[IMG_DST], cfg.dest_level_count);
    for (int a = 0; a < 3; a++) begin
      base_nxt[IMG_SRC][a] = size_field(cfg.source_size[a*COORD_W +: COORD_W]);
      base_nxt[IMG_DST][a] = size_field(cfg.dest_size[a*COORD_W +: COORD_W]);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  // Advance the stage when the next one takes the item or this one is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      level_r  <= level_nxt;
      base_r   <= base_nxt;
      origin_r <= up_req.origin;
      size_r   <= up_req.size;
      last_r   <= up_req.last;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_level  = level_r;
  assign dn_base   = base_r;
  assign dn_origin = origin_r;
  assign dn_size   = size_r;
  assign dn_last   = last_r;

endmodule

/* hw/rtl/rcrc_extent.sv */
// Stage 2: derive each image's extent at the clamped level.
`timescale 1ns / 1ps

module rcrc_extent #(
  parameter int EXTENT_BITS = 16,
  parameter int LVL_W       = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic [1:0][LVL_W-1:0]                  up_level,
  input  logic [1:0][2:0][EXTENT_BITS-1:0]       up_base,
  input  logic [1:0][2:0][rcrc_pkg::COORD_W-1:0] up_origin,
  input  logic [2:0][rcrc_pkg::COORD_W-1:0]      up_size,
  input  logic                                   up_last,
  input  logic [1:0]                             multisample,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output logic [1:0][LVL_W-1:0]                  dn_level,
  output logic [1:0][2:0][EXTENT_BITS-1:0]       dn_ext,
  output logic [1:0][2:0][rcrc_pkg::COORD_W-1:0] dn_origin,
  output logic [2:0][rcrc_pkg::COORD_W-1:0]      dn_size,
  output logic                                   dn_last
);
  import rcrc_pkg::*;

  logic                              valid_r;
  logic [1:0][LVL_W-1:0]             level_r;
  logic [1:0][2:0][EXTENT_BITS-1:0]  ext_r, ext_nxt;
  logic [1:0][2:0][COORD_W-1:0]      origin_r;
  logic [2:0][COORD_W-1:0]           size_r;
  logic                              last_r;

  // Halve per level with a floor of one, or double per level and saturate
  function automatic logic [EXTENT_BITS-1:0] level_ext(input logic [EXTENT_BITS-1:0] base,
                                                       input logic [LVL_W-1:0] lvl,
                                                       input logic ms);
    logic [2*EXTENT_BITS-1:0] wide;
    logic [EXTENT_BITS-1:0]   shr;
    logic [EXTENT_BITS-1:0]   res;
    wide = {{EXTENT_BITS{1'b0}}, base} << lvl;
    shr  = base >> lvl;
    if (ms) begin
      if ((int'(lvl) >= EXTENT_BITS) || (wide[2*EXTENT_BITS-1:EXTENT_BITS] != '0)) begin
        res = '1;
      end else begin
        res = wide[EXTENT_BITS-1:0];
      end
    end else begin
      res = (shr == '0) ? EXTENT_BITS'(1) : shr;
    end
    return res;
  endfunction

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int a = 0; a < 3; a++) begin
        ext_nxt[i][a] = level_ext(up_base[i][a], up_level[i], multisample[i]);
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  // Advance the stage when the next one takes the item or this one is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      level_r  <= up_level;
      ext_r    <= ext_nxt;
      origin_r <= up_origin;
      size_r   <= up_size;
      last_r   <= up_last;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_level  = level_r;
  assign dn_ext    = ext_r;
  assign dn_origin = origin_r;
  assign dn_size   = size_r;
  assign dn_last   = last_r;

endmodule

/* hw/rtl/rcrc_fit.sv */
// Stages 3 and 4: clamp origins, find the room left and clamp the copy size.
`timescale 1ns / 1ps

module rcrc_fit #(
  parameter int EXTENT_BITS = 16,
  parameter int LVL_W       = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic [1:0][LVL_W-1:0]                  up_level,
  input  logic [1:0][2:0][EXTENT_BITS-1:0]       up_ext,
  input  logic [1:0][2:0][rcrc_pkg::COORD_W-1:0] up_origin,
  input  logic [2:0][rcrc_pkg::COORD_W-1:0]      up_size,
  input  logic                                   up_last,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output rcrc_pkg::res_t                         dn_res
);
  import rcrc_pkg::*;

  // Stage 3 registers
  logic                              s3_valid_r;
  logic                              s3_ready;
  logic [1:0][LVL_W-1:0]             s3_level_r;
  logic [1:0][2:0][EXTENT_BITS-1:0]  s3_org_r, s3_org_nxt;
  logic [1:0][2:0][EXTENT_BITS-1:0]  s3_room_r, s3_room_nxt;
  logic [2:0][COORD_W-1:0]           s3_size_r;
  logic                              s3_last_r;

  // Stage 4 registers
  logic                              s4_valid_r;
  logic                              s4_ready;
  res_t                              s4_res_r, s4_res_nxt;

  // Clamp each origin to extent minus one and take the room left
  always_comb begin
    logic [EXTENT_BITS-1:0] lim;
    for (int i = 0; i < 2; i++) begin
      for (int a = 0; a < 3; a++) begin
        lim = up_ext[i][a] - EXTENT_BITS'(1);
        if (up_origin[i][a] > COORD_W'(lim)) begin
          s3_org_nxt[i][a] = lim;
        end else begin
          s3_org_nxt[i][a] = EXTENT_BITS'(up_origin[i][a]);
        end
        s3_room_nxt[i][a] = up_ext[i][a] - s3_org_nxt[i][a];
      end
    end
  end

  assign up_ready = !s3_valid_r || s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (up_ready) begin
      s3_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s3_level_r <= up_level;
      s3_org_r   <= s3_org_nxt;
      s3_room_r  <= s3_room_nxt;
      s3_size_r  <= up_size;
      s3_last_r  <= up_last;
    end
  end

  // Clamp the copy size between one and the smaller room
  always_comb begin
    logic [EXTENT_BITS-1:0] room;
    logic [COORD_W-1:0]     req;
    logic [LEVEL_IN_W-1:0]  lvl;
    for (int i = 0; i < 2; i++) begin
      lvl = LEVEL_IN_W'(s3_level_r[i]);
      s4_res_nxt.level[i] = lvl[LEVEL_OUT_W-1:0];
      for (int a = 0; a < 3; a++) begin
        s4_res_nxt.origin[i][a] = COORD_W'(s3_org_r[i][a]);
      end
    end
    for (int a = 0; a < 3; a++) begin
      room = (s3_room_r[IMG_SRC][a] < s3_room_r[IMG_DST][a]) ?
             s3_room_r[IMG_SRC][a] : s3_room_r[IMG_DST][a];
      req = (s3_size_r[a] > COORD_W'(room)) ? COORD_W'(room) : s3_size_r[a];
      s4_res_nxt.size[a] = (req == '0) ? COORD_W'(1) : req;
    end
    s4_res_nxt.last = s3_last_r;
  end

  assign s3_ready = !s4_valid_r || s4_ready;
  assign s4_ready = dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid_r) begin
      s4_res_r <= s4_res_nxt;
    end
  end

  assign dn_valid = s4_valid_r;
  assign dn_res   = s4_res_r;

endmodule

/* hw/rtl/raster_copy_region_clamp.sv */
// Throughput: one item per cycle through four register stages (level clamp,
// extent shift, origin clamp and room, size clamp); a stalled output holds the
// item and the stages behind it fill their empty slots before backpressure reaches the input.
// Reset (synchronous, rst_n low): all stages empty, configuration back to
// 1x1x1 images with one level each and no multisampling.
`timescale 1ns / 1ps
`include "raster_copy_region_clamp_macros.svh"

module raster_copy_region_clamp #(
  parameter int MAX_LEVELS  = 16,
  parameter int EXTENT_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  rcrc_req_if.sink  in_req,
  rcrc_res_if.source out_res,
  rcrc_cfg_if.sink  cfg_wr
);
  import rcrc_pkg::*;

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam logic [COORD_W:0] EXT_LIMIT = (COORD_W + 1)'((1 << EXTENT_BITS) - 1);

  cfg_t cfg_r, cfg_nxt;
  req_t req;
  res_t res;

  logic                             p1_valid, p1_ready;
  logic [1:0][LVL_W-1:0]            p1_level;
  logic [1:0][2:0][EXTENT_BITS-1:0] p1_base;
  logic [1:0][2:0][COORD_W-1:0]     p1_origin;
  logic [2:0][COORD_W-1:0]          p1_size;
  logic                             p1_last;

  logic                             p2_valid, p2_ready;
  logic [1:0][LVL_W-1:0]            p2_level;
  logic [1:0][2:0][EXTENT_BITS-1:0] p2_ext;
  logic [1:0][2:0][COORD_W-1:0]     p2_origin;
  logic [2:0][COORD_W-1:0]          p2_size;
  logic                             p2_last;

  logic [COORD_W:0] src_x_end, dst_x_end;
  logic             size_nonzero, span_fits;

  // Configuration registers: always ready
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_SOURCE_SIZE:        cfg_nxt.source_size        = cfg_wr.data[SIZE_W-1:0];
        CFG_SOURCE_LEVEL_COUNT: cfg_nxt.source_level_count = cfg_wr.data[LEVEL_IN_W-1:0];
        CFG_DEST_SIZE:          cfg_nxt.dest_size          = cfg_wr.data[SIZE_W-1:0];
        CFG_DEST_LEVEL_COUNT:   cfg_nxt.dest_level_count   = cfg_wr.data[LEVEL_IN_W-1:0];
        CFG_MULTISAMPLE_MODES:  cfg_nxt.multisample_modes  = cfg_wr.data[1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_size        <= SIZE_RESET;
      cfg_r.source_level_count <= COUNT_RESET;
      cfg_r.dest_size          <= SIZE_RESET;
      cfg_r.dest_level_count   <= COUNT_RESET;
      cfg_r.multisample_modes  <= 2'b00;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Gather the request fields
  always_comb begin
    req.level[IMG_SRC]     = in_req.src_level;
    req.level[IMG_DST]     = in_req.dst_level;
    req.origin[IMG_SRC][0] = in_req.src_x;
    req.origin[IMG_SRC][1] = in_req.src_y;
    req.origin[IMG_SRC][2] = in_req.src_z;
    req.origin[IMG_DST][0] = in_req.dst_x;
    req.origin[IMG_DST][1] = in_req.dst_y;
    req.origin[IMG_DST][2] = in_req.dst_z;
    req.size[0]            = in_req.copy_width;
    req.size[1]            = in_req.copy_height;
    req.size[2]            = in_req.copy_depth;
    req.last               = in_req.last_in;
  end

  rcrc_prep #(
    .MAX_LEVELS  (MAX_LEVELS),
    .EXTENT_BITS (EXTENT_BITS),
    .LVL_W       (LVL_W)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_req.valid),
    .up_ready  (in_req.ready),
    .up_req    (req),
    .cfg       (cfg_r),
    .dn_valid  (p1_valid),
    .dn_ready  (p1_ready),
    .dn_level  (p1_level),
    .dn_base   (p1_base),
    .dn_origin (p1_origin),
    .dn_size   (p1_size),
    .dn_last   (p1_last)
  );

  rcrc_extent #(
    .EXTENT_BITS (EXTENT_BITS),
    .LVL_W       (LVL_W)
  ) u_extent (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (p1_valid),
    .up_ready    (p1_ready),
    .up_level    (p1_level),
    .up_base     (p1_base),
    .up_origin   (p1_origin),
    .up_size     (p1_size),
    .up_last     (p1_last),
    .multisample (cfg_r.multisample_modes),
    .dn_valid    (p2_valid),
    .dn_ready    (p2_ready),
    .dn_level    (p2_level),
    .dn_ext      (p2_ext),
    .dn_origin   (p2_origin),
    .dn_size     (p2_size),
    .dn_last     (p2_last)
  );

  rcrc_fit #(
    .EXTENT_BITS (EXTENT_BITS),
    .LVL_W       (LVL_W)
  ) u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (p2_valid),
    .up_ready  (p2_ready),
    .up_level  (p2_level),
    .up_ext    (p2_ext),
    .up_origin (p2_origin),
    .up_size   (p2_size),
    .up_last   (p2_last),
    .dn_valid  (out_res.valid),
    .dn_ready  (out_res.ready),
    .dn_res    (res)
  );

  // Spread the result onto the output channel
  assign out_res.out_src_level = res.level[IMG_SRC];
  assign out_res.out_dst_level = res.level[IMG_DST];
  assign out_res.out_src_x     = res.origin[IMG_SRC][0];
  assign out_res.out_src_y     = res.origin[IMG_SRC][1];
  assign out_res.out_src_z     = res.origin[IMG_SRC][2];
  assign out_res.out_dst_x     = res.origin[IMG_DST][0];
  assign out_res.out_dst_y     = res.origin[IMG_DST][1];
  assign out_res.out_dst_z     = res.origin[IMG_DST][2];
  assign out_res.out_width     = res.size[0];
  assign out_res.out_height    = res.size[1];
  assign out_res.out_depth     = res.size[2];
  assign out_res.last_out      = res.last;

  // End of the copied span in x, for the fit checks
  assign src_x_end = {1'b0, out_res.out_src_x} + {1'b0, out_res.out_width};
  assign dst_x_end = {1'b0, out_res.out_dst_x} + {1'b0, out_res.out_width};

  assign size_nonzero = (out_res.out_width != '0) && (out_res.out_height != '0) &&
                        (out_res.out_depth != '0);
  assign span_fits    = (src_x_end <= EXT_LIMIT) && (dst_x_end <= EXT_LIMIT);

  // Input backpressure only arises from a full, stalled output
  `RCRC_ASSERT_IMP(a_stall_source, clk, rst_n, !in_req.ready, out_res.valid && !out_res.ready)
  // Every delivered copy size is at least one
  `RCRC_ASSERT_IMP(a_size_nonzero, clk, rst_n, out_res.valid, size_nonzero)
  // The clamped copy never runs past the largest extent in x in either image
  `RCRC_ASSERT_IMP(a_span_fits, clk, rst_n, out_res.valid, span_fits)

endmodule

/* tb/sv/rcrc_clamp_checker.sv */
// Checker for the copy region clamp: mirrors register writes, predicts and compares each result.
`timescale 1ns / 1ps

module rcrc_clamp_checker #(
  parameter int MAX_LEVELS  = 16,
  parameter int EXTENT_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  rcrc_req_if  req,
  rcrc_res_if  res,
  rcrc_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding,
  output int   results_seen
);
  import rcrc_pkg::*;

  localparam longint unsigned EXT_MAX = (64'd1 << EXTENT_BITS) - 64'd1;
  localparam int MAX_REPORTS = 10;

  cfg_t  image_cfg;
  res_t  clamped_q[$];
  int    predicted;
  req_t  seen_req;
  res_t  seen_res;
  res_t  want_res;

  string img_tag[2]  = '{"src", "dst"};
  string axis_tag[3] = '{"x", "y", "z"};
  string size_tag[3] = '{"width", "height", "depth"};

  assign outstanding = predicted - results_seen;

  // Base extent of one axis: zero counts as one, saturate at the extent limit
  function automatic longint unsigned base_extent(input logic [SIZE_W-1:0] size, input int axis);
    longint unsigned v;
    v = longint'((size >> (COORD_W * axis)) & 48'hFFFF);
    if (v == 0) v = 1;
    if (v > EXT_MAX) v = EXT_MAX;
    return v;
  endfunction

  // Clamp a requested level to the usable level count minus one
  function automatic int unsigned clamp_level(input logic [LEVEL_IN_W-1:0] want,
                                              input logic [LEVEL_IN_W-1:0] count);
    int unsigned c;
    c = count;
    if (c == 0) c = 1;
    if (c > MAX_LEVELS) c = MAX_LEVELS;
    return (want < c - 1) ? want : c - 1;
  endfunction

  // Extent at a level: halve with a floor of one, or double and saturate when multisampled
  function automatic longint unsigned level_extent(input longint unsigned base,
                                                   input int unsigned lvl, input bit ms);
    longint unsigned v;
    if (ms) begin
      v = base << lvl;
      if (v > EXT_MAX) v = EXT_MAX;
    end else begin
      v = base >> lvl;
      if (v == 0) v = 1;
    end
    return v;
  endfunction

  function automatic res_t clamp_request(input req_t r, input cfg_t c);
    res_t            o;
    int unsigned     lvl[2];
    longint unsigned ext[2];
    longint unsigned org[2];
    longint unsigned room;
    longint unsigned want;
    lvl[IMG_SRC] = clamp_level(r.level[IMG_SRC], c.source_level_count);
    lvl[IMG_DST] = clamp_level(r.level[IMG_DST], c.dest_level_count);
    o.level[IMG_SRC] = LEVEL_OUT_W'(lvl[IMG_SRC]);
    o.level[IMG_DST] = LEVEL_OUT_W'(lvl[IMG_DST]);
    for (int a = 0; a < 3; a++) begin
      ext[IMG_SRC] = level_extent(base_extent(c.source_size, a), lvl[IMG_SRC],
                                  c.multisample_modes[0]);
      ext[IMG_DST] = level_extent(base_extent(c.dest_size, a), lvl[IMG_DST],
                                  c.multisample_modes[1]);
      for (int i = 0; i < 2; i++) begin
        org[i] = r.origin[i][a];
        if (org[i] > ext[i] - 1) org[i] = ext[i] - 1;
        o.origin[i][a] = COORD_W'(org[i]);
      end
      room = ext[IMG_SRC] - org[IMG_SRC];
      if (ext[IMG_DST] - org[IMG_DST] < room) room = ext[IMG_DST] - org[IMG_DST];
      want = r.size[a];
      if (want > room) want = room;
      if (want < 1) want = 1;
      o.size[a] = COORD_W'(want);
    end
    o.last = r.last;
    return o;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    if (mismatches < MAX_REPORTS)
      $display("mismatch at result %0d, %s: expected %0d, got %0d",
               results_seen, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      image_cfg <= '{source_size: SIZE_RESET, source_level_count: COUNT_RESET,
                     dest_size: SIZE_RESET, dest_level_count: COUNT_RESET,
                     multisample_modes: 2'b00};
      clamped_q.delete();
      predicted    <= 0;
      results_seen <= 0;
      mismatches = 0;
    end else begin
      // Mirror register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SOURCE_SIZE:        image_cfg.source_size        <= cfg.data[SIZE_W-1:0];
          CFG_SOURCE_LEVEL_COUNT: image_cfg.source_level_count <= cfg.data[LEVEL_IN_W-1:0];
          CFG_DEST_SIZE:          image_cfg.dest_size          <= cfg.data[SIZE_W-1:0];
          CFG_DEST_LEVEL_COUNT:   image_cfg.dest_level_count   <= cfg.data[LEVEL_IN_W-1:0];
          CFG_MULTISAMPLE_MODES:  image_cfg.multisample_modes  <= cfg.data[1:0];
          default: ;
        endcase
      end

      // Predict each accepted request item
      if (req.valid && req.ready) begin
        seen_req.level[IMG_SRC]     = req.src_level;
        seen_req.level[IMG_DST]     = req.dst_level;
        seen_req.origin[IMG_SRC][0] = req.src_x;
        seen_req.origin[IMG_SRC][1] = req.src_y;
        seen_req.origin[IMG_SRC][2] = req.src_z;
        seen_req.origin[IMG_DST][0] = req.dst_x;
        seen_req.origin[IMG_DST][1] = req.dst_y;
        seen_req.origin[IMG_DST][2] = req.dst_z;
        seen_req.size[0]            = req.copy_width;
        seen_req.size[1]            = req.copy_height;
        seen_req.size[2]            = req.copy_depth;
        seen_req.last               = req.last_in;
        clamped_q.push_back(clamp_request(seen_req, image_cfg));
        predicted <= predicted + 1;
      end

      // Compare each accepted result item with the oldest prediction
      if (res.valid && res.ready) begin
        seen_res.level[IMG_SRC]     = res.out_src_level;
        seen_res.level[IMG_DST]     = res.out_dst_level;
        seen_res.origin[IMG_SRC][0] = res.out_src_x;
        seen_res.origin[IMG_SRC][1] = res.out_src_y;
        seen_res.origin[IMG_SRC][2] = res.out_src_z;
        seen_res.origin[IMG_DST][0] = res.out_dst_x;
        seen_res.origin[IMG_DST][1] = res.out_dst_y;
        seen_res.origin[IMG_DST][2] = res.out_dst_z;
        seen_res.size[0]            = res.out_width;
        seen_res.size[1]            = res.out_height;
        seen_res.size[2]            = res.out_depth;
        seen_res.last               = res.last_out;
        if (clamped_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("result %0d arrived with no request waiting", results_seen);
          mismatches++;
        end else begin
          want_res = clamped_q.pop_front();
          for (int i = 0; i < 2; i++) begin
            if (seen_res.level[i] !== want_res.level[i])
              note_mismatch({img_tag[i], "_level"}, want_res.level[i], seen_res.level[i]);
            for (int a = 0; a < 3; a++)
              if (seen_res.origin[i][a] !== want_res.origin[i][a])
                note_mismatch($sformatf("%s_%s", img_tag[i], axis_tag[a]),
                              want_res.origin[i][a], seen_res.origin[i][a]);
          end
          for (int a = 0; a < 3; a++)
            if (seen_res.size[a] !== want_res.size[a])
              note_mismatch(size_tag[a], want_res.size[a], seen_res.size[a]);
          if (seen_res.last !== want_res.last)
            note_mismatch("last", want_res.last, seen_res.last);
        end
        results_seen <= results_seen + 1;
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the copy region clamp testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
  import rcrc_pkg::*;

  localparam int MAX_LEVELS    = 16;
  localparam int EXTENT_BITS   = 16;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 100;

  logic clk = 1'b0;
  logic rst_n;

  int sender_idle_pct   = 28;
  int receiver_idle_pct = 86;
  int items_sent        = 0;
  int cfg_writes        = 0;
  int mismatches;
  int outstanding;
  int results_seen;

  rcrc_req_if req_ch ();
  rcrc_res_if res_ch ();
  rcrc_cfg_if cfg_ch ();

  raster_copy_region_clamp #(
    .MAX_LEVELS (MAX_LEVELS),
    .EXTENT_BITS(EXTENT_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_res(res_ch),
    .cfg_wr (cfg_ch)
  );

  rcrc_clamp_checker #(
    .MAX_LEVELS (MAX_LEVELS),
    .EXTENT_BITS(EXTENT_BITS)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  function automatic req_t make_request(
    input logic [LEVEL_IN_W-1:0] sl, input logic [COORD_W-1:0] sx, sy, sz,
    input logic [LEVEL_IN_W-1:0] dl, input logic [COORD_W-1:0] dx, dy, dz,
    input logic [COORD_W-1:0] w, h, d, input logic lst);
    req_t r;
    r.level[IMG_SRC]     = sl;
    r.origin[IMG_SRC][0] = sx;
    r.origin[IMG_SRC][1] = sy;
    r.origin[IMG_SRC][2] = sz;
    r.level[IMG_DST]     = dl;
    r.origin[IMG_DST][0] = dx;
    r.origin[IMG_DST][1] = dy;
    r.origin[IMG_DST][2] = dz;
    r.size[0]            = w;
    r.size[1]            = h;
    r.size[2]            = d;
    r.last               = lst;
    return r;
  endfunction

  // Coordinates and copy sizes: mostly small or near image edges, some wide or extreme
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(3))
      0:       return COORD_W'($urandom_range(65535));
      1:       return COORD_W'($urandom_range(15));
      2:       return COORD_W'($urandom_range(600));
      default: return ($urandom_range(1) != 0) ? 16'hFFFF : COORD_W'($urandom_range(1));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_dim();
    case ($urandom_range(3))
      0:       return COORD_W'($urandom_range(65535));
      1:       return COORD_W'($urandom_range(64));
      2:       return COORD_W'(1 << $urandom_range(15));
      default: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [LEVEL_IN_W-1:0] pick_count();
    case ($urandom_range(7))
      0:       return '0;
      1:       return LEVEL_IN_W'($urandom_range(17, 31));
      default: return LEVEL_IN_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [LEVEL_IN_W-1:0] pick_level();
    return LEVEL_IN_W'(($urandom_range(1) != 0) ? $urandom_range(31) : $urandom_range(17));
  endfunction

  function automatic req_t rand_request();
    return make_request(pick_level(), pick_coord(), pick_coord(), pick_coord(),
                        pick_level(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord(), 1'($urandom_range(1)));
  endfunction

  // Offer one request item after a random gap and hold it until accepted
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.src_level   <= r.level[IMG_SRC];
    req_ch.src_x       <= r.origin[IMG_SRC][0];
    req_ch.src_y       <= r.origin[IMG_SRC][1];
    req_ch.src_z       <= r.origin[IMG_SRC][2];
    req_ch.dst_level   <= r.level[IMG_DST];
    req_ch.dst_x       <= r.origin[IMG_DST][0];
    req_ch.dst_y       <= r.origin[IMG_DST][1];
    req_ch.dst_z       <= r.origin[IMG_DST][2];
    req_ch.copy_width  <= r.size[0];
    req_ch.copy_height <= r.size[1];
    req_ch.copy_depth  <= r.size[2];
    req_ch.last_in     <= r.last;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result is back, then let the pipe settle
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back; level counts and modes may carry junk upper bits
  task automatic program_images(
    input logic [SIZE_W-1:0] src_size, input logic [LEVEL_IN_W-1:0] src_count,
    input logic [SIZE_W-1:0] dst_size, input logic [LEVEL_IN_W-1:0] dst_count,
    input logic [1:0] ms);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] val[5];
    logic [CFG_DATA_W-1:0] junk;
    junk   = ($urandom_range(1) != 0) ? CFG_DATA_W'({$urandom(), $urandom()}) : '0;
    idx[0] = CFG_SOURCE_SIZE;
    idx[1] = CFG_SOURCE_LEVEL_COUNT;
    idx[2] = CFG_DEST_SIZE;
    idx[3] = CFG_DEST_LEVEL_COUNT;
    idx[4] = CFG_MULTISAMPLE_MODES;
    val[0] = src_size;
    val[1] = {junk[CFG_DATA_W-1:LEVEL_IN_W], src_count};
    val[2] = dst_size;
    val[3] = {junk[CFG_DATA_W-1:LEVEL_IN_W], dst_count};
    val[4] = {junk[CFG_DATA_W-1:2], ms};
    for (int k = 0; k < 5; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      do @(posedge clk); while (!cfg_ch.ready);
      cfg_writes++;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int drain_at;
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.src_level   <= '0;
    req_ch.src_x       <= '0;
    req_ch.src_y       <= '0;
    req_ch.src_z       <= '0;
    req_ch.dst_level   <= '0;
    req_ch.dst_x       <= '0;
    req_ch.dst_y       <= '0;
    req_ch.dst_z       <= '0;
    req_ch.copy_width  <= '0;
    req_ch.copy_height <= '0;
    req_ch.copy_depth  <= '0;
    req_ch.last_in     <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset images are 1x1x1 with one level: everything clamps to zero origin, size one
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_request(make_request(31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));

    // Largest source, zero-size destination with a zero level count
    wait_drained();
    program_images(48'hFFFF_FFFF_FFFF, 5'd16, 48'h0, 5'd0, 2'b00);
    send_request(make_request(15, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_request(make_request(0, 0, 0, 0, 31, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_request(0, 100, 200, 300, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              1'b0));
    send_request(make_request(16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));

    // Both images multisampled, level counts above the maximum, doubled extents saturate
    wait_drained();
    program_images(48'hFFFF_FFFF_FFFF, 5'd31, 48'h8000_4000_0001, 5'd20, 2'b11);
    send_request(make_request(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_request(make_request(15, 1, 2, 3, 15, 5, 6, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_request(1, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 1'b0));
    send_request(make_request(31, 16'hFFFE, 16'hFFFE, 16'hFFFE, 31, 16'hFFFE, 16'hFFFE,
                              16'hFFFE, 2, 2, 2, 1'b0));

    // Mixed sizes, source multisampled only
    wait_drained();
    program_images(48'h0400_0100_0010, 5'd5, 48'h0003_0007_0200, 5'd16, 2'b01);
    send_request(make_request(4, 3, 3, 3, 9, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_request(2, 15, 63, 1023, 0, 511, 6, 2, 0, 0, 0, 1'b0));
    send_request(make_request(7, 8, 8, 8, 3, 100, 1, 1, 10, 10, 10, 1'b1));

    // Zero source fields, destination multisampled only
    wait_drained();
    program_images(48'h0001_FFFF_0000, 5'd1, 48'hFFFF_0000_0001, 5'd31, 2'b10);
    send_request(make_request(0, 0, 0, 0, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 1'b0));
    send_request(make_request(5, 1, 1, 1, 30, 1, 1, 1, 1, 1, 1, 1'b1));
    send_request(make_request(0, 16'hFFFF, 0, 16'hFFFF, 16, 0, 16'hFFFF, 0, 16'hFFFF, 0,
                              16'hFFFF, 1'b0));

    // Random phases, each with fresh image settings and one full drain midway
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      if (p < 3) begin
        sender_idle_pct   = 28;
        receiver_idle_pct = 86;
      end else if (p < 5) begin
        sender_idle_pct   = 86;
        receiver_idle_pct = 28;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      program_images({pick_dim(), pick_dim(), pick_dim()}, pick_count(),
                     {pick_dim(), pick_dim(), pick_dim()}, pick_count(),
                     2'($urandom_range(3)));
      drain_at = $urandom_range(20, 80);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == drain_at) wait_drained();
        send_request(rand_request());
      end
    end
    wait_drained();

    $display("Sent %0d copy requests across %0d register writes; %0d results compared.",
             items_sent, cfg_writes, results_seen);
    $display("Covered zero and oversized counts, all multisample modes, three idling mixes.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule
  initial begin
    #2_000_000;
    $display("timeout with %0d results still outstanding", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
